FILE: sv/cgff_pkg.sv
`default_nettype none

package cgff_pkg;

  // Default grid store geometry.
  localparam int unsigned MAX_COLS_DEF = 64;
  localparam int unsigned MAX_ROWS_DEF = 32;

  // Field widths, fixed by the interface.
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned GRID_W_W = 7;
  localparam int unsigned GRID_H_W = 6;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 7;

  // Blank glyph, white on black, bright.
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h20E2;

  // Reset values of the size registers before clamping.
  localparam int unsigned GRID_W_RST = 64;
  localparam int unsigned GRID_H_RST = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_WIPE  = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 4'd0,
    REG_GRID_HEIGHT = 4'd1
  } cfg_reg_e;

  // Clamp a size register value to 1..maxv.
  function automatic logic [GRID_W_W-1:0] clamp_dim(logic [GRID_W_W-1:0] v, int unsigned maxv);
    logic [GRID_W_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = GRID_W_W'(1);
    end else if (int'(v) > int'(maxv)) begin
      r = GRID_W_W'(maxv);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cell_grid_flood_fill.sv
`default_nettype none
// Wipe: the sweep writes every grid entry with the wipe value, one entry per cycle.
// Flood fill: bound by the single port pair of the grid memory. One item at a time;
//   in_stall_o is high until done.
// Reset: asynchronous, active low. After reset the grid is swept to the blank cell, one
//   entry per cycle; items stall meanwhile, config is taken.

module cell_grid_flood_fill #(
  parameter int unsigned MAX_COLS = cgff_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = cgff_pkg::MAX_ROWS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // item input
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [cgff_pkg::ACTION_W-1:0]   action_i,
  input  wire logic [cgff_pkg::COL_W-1:0]      col_i,
  input  wire logic [cgff_pkg::ROW_W-1:0]      row_i,
  input  wire logic [cgff_pkg::CELL_W-1:0]     cell_value_i,
  input  wire logic [cgff_pkg::CELL_W-1:0]     match_value_i,
  // result output
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [cgff_pkg::CELL_W-1:0]          read_cell_o,
  output logic                                 out_of_bounds_o,
  // config write
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [cgff_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [cgff_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned PW  = $clog2(CELL_COUNT + 1);
  localparam int unsigned XW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned YW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned SW  = XW + YW;
  localparam int unsigned WW  = cgff_pkg::GRID_W_W;
  localparam int unsigned HW  = cgff_pkg::GRID_H_W;
  localparam int unsigned CXW = (XW + 1 > WW) ? XW + 1 : WW;
  localparam int unsigned CYW = (YW + 1 > HW) ? YW + 1 : HW;
  localparam int unsigned CW  = cgff_pkg::CELL_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,  // grid read in flight for a read item
    S_PROBE = 8'b0000_0100,  // candidate cell data back: paint and push
    S_NEIGH = 8'b0000_1000,  // pick next neighbor of current cell
    S_POP   = 8'b0001_0000,  // pop next cell or finish
    S_POPW  = 8'b0010_0000,  // stack read in flight
    S_SWEEP = 8'b0100_0000,  // wipe / post-reset clear
    S_DONE  = 8'b1000_0000   // hand result to output register
  } state_e;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cgff_pkg::clamp_dim(WW'(cgff_pkg::GRID_W_RST), MAX_COLS);
      height_q <= HW'(cgff_pkg::clamp_dim(WW'(cgff_pkg::GRID_H_RST), MAX_ROWS));
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cgff_pkg::REG_GRID_WIDTH: begin
          width_q <= cgff_pkg::clamp_dim(cfg_data_i, MAX_COLS);
        end
        cgff_pkg::REG_GRID_HEIGHT: begin
          height_q <= HW'(cgff_pkg::clamp_dim({1'b0, cfg_data_i[HW-1:0]}, MAX_ROWS));
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Grid memory and fill stack: one write, one registered read each
  // ---------------------------------------------------------------------------
  logic [CW-1:0] grid_mem [CELL_COUNT];
  logic          g_we, g_re;
  logic [AW-1:0] g_waddr, g_raddr;
  logic [CW-1:0] g_wdata, g_rdata_q;

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      grid_mem[g_waddr] <= g_wdata;
    end
    if (g_re) begin
      g_rdata_q <= grid_mem[g_raddr];
    end
  end

  logic [SW-1:0] stk_mem [CELL_COUNT];
  logic          s_we, s_re;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata_q;

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      stk_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_q <= stk_mem[s_raddr];
    end
  end

  function automatic logic [AW-1:0] cell_addr(logic [XW-1:0] x, logic [YW-1:0] y);
    return AW'(AW'(y) * AW'(MAX_COLS) + AW'(x));
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e         state_q, state_d;
  logic [PW-1:0]  ptr_q, ptr_d;
  logic [AW-1:0]  sweep_q, sweep_d;
  logic [CW-1:0]  sweep_val_q, sweep_val_d;
  logic           wipe_q, wipe_d;    // sweep came from a wipe item
  logic           seed_q, seed_d;    // probe is the seed cell
  dir_e           dir_q, dir_d;
  logic [XW-1:0]  cur_x_q, cur_x_d, cand_x_q, cand_x_d;
  logic [YW-1:0]  cur_y_q, cur_y_d, cand_y_q, cand_y_d;
  logic [CW-1:0]  match_q, match_d, fill_q, fill_d;
  logic [CW-1:0]  res_cell_q, res_cell_d;
  logic           res_oob_q, res_oob_d;

  logic           in_acc, out_free, in_oob;
  logic [PW-1:0]  ptr_m1;
  logic [CXW-1:0] nx_ext;
  logic [CYW-1:0] ny_ext;
  logic           nb_ok;
  logic [XW-1:0]  nb_x;
  logic [YW-1:0]  nb_y;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_oob     = ({1'b0, col_i} >= width_q) || ({1'b0, row_i} >= height_q);
  assign ptr_m1     = ptr_q - PW'(1);

  // Neighbor of the current cell in direction dir_q; nb_ok is set when it lies in the grid.
  always_comb begin
    nx_ext = CXW'(cur_x_q);
    ny_ext = CYW'(cur_y_q);
    nb_ok  = 1'b0;
    case (dir_q)
      DIR_LEFT: begin
        nx_ext = CXW'(cur_x_q) - CXW'(1);
        nb_ok  = (cur_x_q != '0);
      end
      DIR_RIGHT: begin
        nx_ext = CXW'(cur_x_q) + CXW'(1);
        nb_ok  = (nx_ext < CXW'(width_q));
      end
      DIR_UP: begin
        ny_ext = CYW'(cur_y_q) - CYW'(1);
        nb_ok  = (cur_y_q != '0);
      end
      DIR_DOWN: begin
        ny_ext = CYW'(cur_y_q) + CYW'(1);
        nb_ok  = (ny_ext < CYW'(height_q));
      end
      default: begin
      end
    endcase
    nb_x = nx_ext[XW-1:0];
    nb_y = ny_ext[YW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    sweep_d     = sweep_q;
    sweep_val_d = sweep_val_q;
    wipe_d      = wipe_q;
    seed_d      = seed_q;
    dir_d       = dir_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    cand_x_d    = cand_x_q;
    cand_y_d    = cand_y_q;
    match_d     = match_q;
    fill_d      = fill_q;
    res_cell_d  = res_cell_q;
    res_oob_d   = res_oob_q;

    g_we    = 1'b0;
    g_waddr = cell_addr(cand_x_q, cand_y_q);
    g_wdata = fill_q;
    g_re    = 1'b0;
    g_raddr = cell_addr(XW'(col_i), YW'(row_i));
    s_we    = 1'b0;
    s_waddr = ptr_q[AW-1:0];
    s_wdata = {cand_y_q, cand_x_q};
    s_re    = 1'b0;
    s_raddr = ptr_m1[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_cell_d = '0;
          res_oob_d  = in_oob;
          if (action_i == cgff_pkg::ACT_WIPE) begin
            res_oob_d   = 1'b0;
            sweep_d     = '0;
            sweep_val_d = cell_value_i;
            wipe_d      = 1'b1;
            state_d     = S_SWEEP;
          end else if (in_oob) begin
            state_d = S_DONE;
          end else begin
            case (action_i)
              cgff_pkg::ACT_READ: begin
                g_re    = 1'b1;
                state_d = S_READ;
              end
              cgff_pkg::ACT_WRITE: begin
                g_we    = 1'b1;
                g_waddr = cell_addr(XW'(col_i), YW'(row_i));
                g_wdata = cell_value_i;
                state_d = S_DONE;
              end
              default: begin
                // flood fill: probe the seed unless it is a no-op
                if (match_value_i == cell_value_i) begin
                  state_d = S_DONE;
                end else begin
                  g_re     = 1'b1;
                  cand_x_d = XW'(col_i);
                  cand_y_d = YW'(row_i);
                  match_d  = match_value_i;
                  fill_d   = cell_value_i;
                  seed_d   = 1'b1;
                  ptr_d    = '0;
                  state_d  = S_PROBE;
                end
              end
            endcase
          end
        end
      end

      S_READ: begin
        res_cell_d = g_rdata_q;
        state_d    = S_DONE;
      end

      S_PROBE: begin
        if (g_rdata_q == match_q) begin
          g_we = 1'b1;
          if (ptr_q < PW'(CELL_COUNT)) begin
            s_we  = 1'b1;
            ptr_d = ptr_q + PW'(1);
          end
        end
        if (seed_q || dir_q == DIR_DOWN) begin
          seed_d  = 1'b0;
          state_d = S_POP;
        end else begin
          dir_d   = dir_e'(dir_q + 2'd1);
          state_d = S_NEIGH;
        end
      end

      S_NEIGH: begin
        if (nb_ok) begin
          g_re     = 1'b1;
          g_raddr  = cell_addr(nb_x, nb_y);
          cand_x_d = nb_x;
          cand_y_d = nb_y;
          state_d  = S_PROBE;
        end else if (dir_q == DIR_DOWN) begin
          state_d = S_POP;
        end else begin
          dir_d = dir_e'(dir_q + 2'd1);
        end
      end

      S_POP: begin
        if (ptr_q == '0) begin
          state_d = S_DONE;
        end else begin
          s_re    = 1'b1;
          ptr_d   = ptr_m1;
          state_d = S_POPW;
        end
      end

      S_POPW: begin
        cur_x_d = s_rdata_q[XW-1:0];
        cur_y_d = s_rdata_q[SW-1:XW];
        dir_d   = DIR_LEFT;
        state_d = S_NEIGH;
      end

      S_SWEEP: begin
        g_we    = 1'b1;
        g_waddr = sweep_q;
        g_wdata = sweep_val_q;
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == AW'(CELL_COUNT - 1)) begin
          sweep_d = '0;
          wipe_d  = 1'b0;
          state_d = wipe_q ? S_DONE : S_IDLE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;   // clearing pass after reset
      ptr_q       <= '0;
      sweep_q     <= '0;
      sweep_val_q <= cgff_pkg::BLANK_CELL;
      wipe_q      <= 1'b0;
      seed_q      <= 1'b0;
      dir_q       <= DIR_LEFT;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      sweep_q     <= sweep_d;
      sweep_val_q <= sweep_val_d;
      wipe_q      <= wipe_d;
      seed_q      <= seed_d;
      dir_q       <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    cand_x_q   <= cand_x_d;
    cand_y_q   <= cand_y_d;
    match_q    <= match_d;
    fill_q     <= fill_d;
    res_cell_q <= res_cell_d;
    res_oob_q  <= res_oob_d;
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a result while the next item is taken
  // ---------------------------------------------------------------------------
  logic          out_valid_q;
  logic [CW-1:0] read_cell_q;
  logic          oob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      read_cell_q <= res_cell_q;
      oob_q       <= res_oob_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_cell_o     = read_cell_q;
  assign out_of_bounds_o = oob_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ptr_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> ptr_q == '0)
    else $error("fill stack not empty between items");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PW'(CELL_COUNT))
    else $error("fill stack pointer beyond depth");

  a_paint_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE && g_we) |-> g_rdata_q == match_q)
    else $error("fill painted a non-matching cell");

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_bounds_o) |-> read_cell_o == '0)
    else $error("out-of-bounds result carries cell data");

  a_done_from: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside done state");

endmodule

`default_nettype wire
